// ===== design/u8d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// types, byte class constants and helpers shared by the utf-8 decoder files
// ----------------------------------------------------------------------------
package u8d_pkg;

    // byte classes
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    // payload bits kept from each byte kind
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    // pending byte count codes
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_LEAD = 2'd1;
    localparam logic [1:0] HELD_BOTH = 2'd2;

    // number of result slots one item can fill
    localparam int MAX_UNITS = 3;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  bytes_used;
    } t_unit;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] second;
        logic [1:0] count;
    } t_held;

    typedef struct packed {
        t_unit [MAX_UNITS-1:0] units;
        logic [1:0]            n_units;
        t_held                 held;
    } t_decode;

    function automatic logic is_lead2(input logic [7:0] b);
        return (b & LEAD2_MASK) == LEAD2_CODE;
    endfunction

    function automatic logic is_lead3(input logic [7:0] b);
        return (b & LEAD3_MASK) == LEAD3_CODE;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_CODE;
    endfunction

endpackage

// ===== design/utf8_to_utf16_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// utf-8 byte stream in, 16-bit basic multilingual plane code units out
// ----------------------------------------------------------------------------
// One UTF-8 byte is taken per item and decoded combinationally against the up
// to two pending bytes; the code units it releases (zero to three) land in a
// three-entry result buffer that drains one unit per cycle while the output side
// does not stall. A byte that releases zero or one unit is followed by the next
// byte in the very next cycle unless the output stalls, so ordinary text streams
// at one byte per clock even with a unit still waiting at the output. A byte
// that releases two or three units (a broken sequence or an end-of-text flush)
// holds the input until the buffer is down to its last unit and the output
// does not stall. Broken sequences come out as raw byte values with bytes_used
// of one; overlong forms and surrogates are decoded without checks. last_of_run
// marks the final unit caused by one input byte. Reset clears all pending bytes.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder
    import u8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte side
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    // code unit side
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_unit,
    output logic [1:0]  o_bytes_used,
    output logic        o_last_of_run
);

    // pending bytes
    t_held r_held;
    t_held n_held;

    // result buffer, slot 0 is the head shown at the output
    t_unit [MAX_UNITS-1:0] r_slot;
    t_unit [MAX_UNITS-1:0] n_slot;
    logic  [1:0]           r_cnt;
    logic  [1:0]           n_cnt;

    t_decode dec;
    logic    in_take;
    logic    out_take;

    u8d_decode u_decode (
        .i_held        (r_held),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_decode      (dec)
    );

    // room for a new item once the buffer is empty or its last unit leaves now
    assign o_stall  = !((r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall));
    assign in_take  = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;

    assign o_valid       = (r_cnt != 2'd0);
    assign o_code_unit   = r_slot[0].code_unit;
    assign o_bytes_used  = r_slot[0].bytes_used;
    assign o_last_of_run = (r_cnt == 2'd1);

    always_comb begin
        n_held = r_held;
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (in_take) begin
            // buffer is empty or being emptied this cycle
            n_held = dec.held;
            n_slot = dec.units;
            n_cnt  = dec.n_units;
        end else if (out_take) begin
            // shift towards the head
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_cnt     = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_cnt  <= 2'd0;
        end else begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

    // slots carry payload only
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    // pending count never reaches three
    a_held_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held.count != 2'd3)
        else $error("pending byte count out of range");

    // a held lead is always a two or three byte lead
    a_held_lead_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held.count == HELD_LEAD) |-> (is_lead2(r_held.lead) || is_lead3(r_held.lead)))
        else $error("held lead is not a multi-byte lead");

    // two pending bytes means a three byte lead and a continuation
    a_held_both_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held.count == HELD_BOTH) |-> (is_lead3(r_held.lead) && is_cont(r_held.second)))
        else $error("pending pair is not a three byte prefix");

    // a new item is never taken over unsent units
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |-> ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take)))
        else $error("item accepted while results still pending");

endmodule

// ===== design/u8d_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_decode
// single-pass decode of one byte against the pending bytes: result list and
// next pending state
// ----------------------------------------------------------------------------
module u8d_decode
    import u8d_pkg::*;
(
    input  t_held      i_held,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output t_decode    o_decode
);

    t_decode    d;
    logic       fresh;
    logic [1:0] n;
    logic [7:0] b;

    always_comb begin
        d     = '0;
        d.held = i_held;
        fresh = 1'b0;
        n     = 2'd0;
        b     = i_text_byte;

        case (i_held.count)
            HELD_LEAD: begin
                if (is_lead2(i_held.lead)) begin
                    d.held.count = HELD_NONE;
                    if (is_cont(b)) begin
                        d.units[n] = '{code_unit: {5'd0, i_held.lead[4:0] & LEAD2_BITS[4:0],
                                                   b[5:0] & CONT_BITS[5:0]},
                                       bytes_used: 2'd2};
                        n = n + 2'd1;
                    end else begin
                        d.units[n] = '{code_unit: {8'd0, i_held.lead}, bytes_used: 2'd1};
                        n = n + 2'd1;
                        fresh = 1'b1;
                    end
                end else if (is_lead3(i_held.lead)) begin
                    if (is_cont(b)) begin
                        d.held.second = b;
                        d.held.count  = HELD_BOTH;
                    end else begin
                        d.held.count = HELD_NONE;
                        d.units[n] = '{code_unit: {8'd0, i_held.lead}, bytes_used: 2'd1};
                        n = n + 2'd1;
                        fresh = 1'b1;
                    end
                end else begin
                    d.held.count = HELD_NONE;
                    fresh = 1'b1;
                end
            end
            HELD_BOTH: begin
                d.held.count = HELD_NONE;
                if (is_cont(b)) begin
                    d.units[n] = '{code_unit: {i_held.lead[3:0] & LEAD3_BITS[3:0],
                                               i_held.second[5:0] & CONT_BITS[5:0],
                                               b[5:0] & CONT_BITS[5:0]},
                                   bytes_used: 2'd3};
                    n = n + 2'd1;
                end else begin
                    d.units[n] = '{code_unit: {8'd0, i_held.lead}, bytes_used: 2'd1};
                    n = n + 2'd1;
                    d.units[n] = '{code_unit: {8'd0, i_held.second}, bytes_used: 2'd1};
                    n = n + 2'd1;
                    fresh = 1'b1;
                end
            end
            default: begin
                d.held.count = HELD_NONE;
                fresh = 1'b1;
            end
        endcase

        // byte handled as if nothing were pending
        if (fresh) begin
            if (is_lead2(b) || is_lead3(b)) begin
                d.held.lead  = b;
                d.held.count = HELD_LEAD;
            end else begin
                d.units[n] = '{code_unit: {8'd0, b}, bytes_used: 2'd1};
                n = n + 2'd1;
            end
        end

        // end of text flushes pending bytes raw, lead first
        if (i_end_of_text) begin
            if (d.held.count == HELD_LEAD || d.held.count == HELD_BOTH) begin
                d.units[n] = '{code_unit: {8'd0, d.held.lead}, bytes_used: 2'd1};
                n = n + 2'd1;
                if (d.held.count == HELD_BOTH) begin
                    d.units[n] = '{code_unit: {8'd0, d.held.second}, bytes_used: 2'd1};
                    n = n + 2'd1;
                end
            end
            d.held.count = HELD_NONE;
        end

        d.n_units = n;
        o_decode  = d;
    end

endmodule

// ===== test/u8d_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_unit_checker
// watches both channels of the utf-8 decoder, predicts each code unit and
// compares every accepted unit with the oldest one awaited
// ----------------------------------------------------------------------------
module u8d_unit_checker
    import u8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte side
    input  logic        i_byte_valid,
    input  logic        i_byte_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    // code unit side
    input  logic        i_unit_valid,
    input  logic        i_unit_stall,
    input  logic [15:0] i_code_unit,
    input  logic [1:0]  i_bytes_used,
    input  logic        i_last_of_run,
    // tallies for the testbench top
    output int          o_fail_count,
    output int          o_awaited,
    output int          o_units_checked,
    output int          o_units_decoded
);

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  bytes_used;
        logic        last_of_run;
    } t_awaited_unit;

    t_awaited_unit awaited_units[$];

    // pending bytes of the sequence being assembled
    logic [7:0] pend_lead;
    logic [7:0] pend_second;
    logic [1:0] pend_count;

    int         fail_total;
    int         checked_total;
    int         decoded_total;

    function automatic logic starts_pair(input logic [7:0] b);
        return b[7:5] == 3'b110;
    endfunction

    function automatic logic starts_triple(input logic [7:0] b);
        return b[7:4] == 4'b1110;
    endfunction

    function automatic logic is_trailer(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic t_awaited_unit make_unit(input logic [15:0] cu,
                                                input logic [1:0] used);
        return '{code_unit: cu, bytes_used: used, last_of_run: 1'b0};
    endfunction

    // works out the code units one accepted byte releases
    task automatic decode_text_byte(input logic [7:0] b, input logic flush);
        t_awaited_unit units [MAX_UNITS];
        int            n;
        logic          fresh;
        n     = 0;
        fresh = 1'b0;
        case (pend_count)
            HELD_LEAD: begin
                if (starts_pair(pend_lead)) begin
                    pend_count = HELD_NONE;
                    if (is_trailer(b)) begin
                        units[n] = make_unit({5'd0, pend_lead[4:0], b[5:0]}, 2'd2);
                        n++;
                    end else begin
                        units[n] = make_unit({8'h00, pend_lead}, 2'd1);
                        n++;
                        fresh = 1'b1;
                    end
                end else if (starts_triple(pend_lead)) begin
                    if (is_trailer(b)) begin
                        pend_second = b;
                        pend_count  = HELD_BOTH;
                    end else begin
                        pend_count = HELD_NONE;
                        units[n]   = make_unit({8'h00, pend_lead}, 2'd1);
                        n++;
                        fresh = 1'b1;
                    end
                end else begin
                    fresh = 1'b1;
                end
            end
            HELD_BOTH: begin
                pend_count = HELD_NONE;
                if (is_trailer(b)) begin
                    units[n] = make_unit({pend_lead[3:0], pend_second[5:0], b[5:0]}, 2'd3);
                    n++;
                end else begin
                    units[n] = make_unit({8'h00, pend_lead}, 2'd1);
                    n++;
                    units[n] = make_unit({8'h00, pend_second}, 2'd1);
                    n++;
                    fresh = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // byte taken as if nothing were pending
        if (fresh) begin
            pend_count = HELD_NONE;
            if (starts_pair(b) || starts_triple(b)) begin
                pend_lead  = b;
                pend_count = HELD_LEAD;
            end else begin
                units[n] = make_unit({8'h00, b}, 2'd1);
                n++;
            end
        end

        // end of text: whatever is pending goes out raw, lead first
        if (flush) begin
            if (pend_count == HELD_LEAD || pend_count == HELD_BOTH) begin
                units[n] = make_unit({8'h00, pend_lead}, 2'd1);
                n++;
                if (pend_count == HELD_BOTH) begin
                    units[n] = make_unit({8'h00, pend_second}, 2'd1);
                    n++;
                end
            end
            pend_count = HELD_NONE;
        end

        if (n > 0) begin
            units[n-1].last_of_run = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            awaited_units.push_back(units[k]);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_awaited_unit want;
        if (!i_rst_n) begin
            awaited_units.delete();
            pend_lead     = 8'h00;
            pend_second   = 8'h00;
            pend_count    = HELD_NONE;
            fail_total    = 0;
            checked_total = 0;
            decoded_total = 0;
        end else begin
            if (i_byte_valid === 1'b1 && i_byte_stall === 1'b0) begin
                decode_text_byte(i_text_byte, i_end_of_text);
            end
            if (i_unit_valid === 1'b1 && i_unit_stall === 1'b0) begin
                if (awaited_units.size() == 0) begin
                    $error("code unit %h arrived with nothing awaited", i_code_unit);
                    fail_total++;
                end else begin
                    want = awaited_units.pop_front();
                    checked_total++;
                    if (want.bytes_used != 2'd1) begin
                        decoded_total++;
                    end
                    if (i_code_unit !== want.code_unit) begin
                        $error("code_unit: expected %h, got %h", want.code_unit, i_code_unit);
                        fail_total++;
                    end
                    if (i_bytes_used !== want.bytes_used) begin
                        $error("bytes_used: expected %0d, got %0d",
                               want.bytes_used, i_bytes_used);
                        fail_total++;
                    end
                    if (i_last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, i_last_of_run);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count    <= fail_total;
        o_awaited       <= awaited_units.size();
        o_units_checked <= checked_total;
        o_units_decoded <= decoded_total;
    end

endmodule

// ===== test/tb_utf8_to_utf16_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_stream_decoder
// drives utf-8 text into the decoder under random idling and back-pressure;
// the checker beside the block predicts and compares every code unit
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_stream_decoder;

    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 300000;
    // quiet cycles allowed after the last awaited unit has come
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_text_item;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  text_byte = 8'h00;
    logic        end_of_text = 1'b0;
    logic        unit_valid;
    logic        unit_stall = 1'b0;
    logic [15:0] code_unit;
    logic [1:0]  bytes_used;
    logic        last_of_run;

    int          fail_count;
    int          awaited;
    int          units_checked;
    int          units_decoded;

    t_text_item  text_q[$];
    int          bytes_sent = 0;
    int          cycle_count = 0;

    // idling controls shared with the receiver process
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          hold_request = 0;

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    utf8_to_utf16_stream_decoder u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (byte_valid),
        .o_stall       (byte_stall),
        .i_text_byte   (text_byte),
        .i_end_of_text (end_of_text),
        .o_valid       (unit_valid),
        .i_stall       (unit_stall),
        .o_code_unit   (code_unit),
        .o_bytes_used  (bytes_used),
        .o_last_of_run (last_of_run)
    );

    u8d_unit_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_byte_valid    (byte_valid),
        .i_byte_stall    (byte_stall),
        .i_text_byte     (text_byte),
        .i_end_of_text   (end_of_text),
        .i_unit_valid    (unit_valid),
        .i_unit_stall    (unit_stall),
        .i_code_unit     (code_unit),
        .i_bytes_used    (bytes_used),
        .i_last_of_run   (last_of_run),
        .o_fail_count    (fail_count),
        .o_awaited       (awaited),
        .o_units_checked (units_checked),
        .o_units_decoded (units_decoded)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // code unit receiver: one stall length drawn per unit, and a long hold-off
    // when the stimulus asks for one, so that the block backs up into its input
    initial begin : unit_receiver
        int stall_len;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request > 0) begin
                stall_len    = hold_request;
                hold_request = 0;
            end else begin
                stall_len = rx_idle ? $urandom_range(0, 18) : 0;
            end
            if (stall_len > 0) begin
                unit_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            unit_stall <= 1'b0;
            do @(posedge clk); while (unit_valid !== 1'b1);
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic eot);
        text_q.push_back('{text_byte: b, end_of_text: eot});
    endtask

    // random end-of-text marks land anywhere, mid-sequence too
    function automatic logic random_eot();
        return $urandom_range(0, 24) == 0;
    endfunction

    function automatic logic [7:0] random_trailer();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // any byte that is not a continuation byte, so a sequence breaks on it
    function automatic logic [7:0] random_breaker();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) begin
            b[6] = 1'b1;
        end
        return b;
    endfunction

    // mostly well-formed text with random content, the rest noise and
    // broken sequences
    task automatic add_random_text(input int count);
        int target;
        int kind;
        target = text_q.size() + count;
        while (text_q.size() < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // plain ascii
                add_byte(8'($urandom_range(0, 127)), random_eot());
            end else if (kind < 65) begin
                // two-byte sequence
                add_byte(8'hC0 | 8'($urandom_range(0, 31)), random_eot());
                add_byte(random_trailer(), random_eot());
            end else if (kind < 85) begin
                // three-byte sequence
                add_byte(8'hE0 | 8'($urandom_range(0, 15)), random_eot());
                add_byte(random_trailer(), random_eot());
                add_byte(random_trailer(), random_eot());
            end else begin
                case ($urandom_range(0, 3))
                    0: add_byte(8'($urandom_range(0, 255)), random_eot());
                    1: add_byte(random_trailer(), random_eot());
                    2: begin
                        // lead of two or three broken straight away
                        add_byte($urandom_range(0, 1) ? (8'hC0 | 8'($urandom_range(0, 31)))
                                                      : (8'hE0 | 8'($urandom_range(0, 15))),
                                 random_eot());
                        add_byte(random_breaker(), random_eot());
                    end
                    default: begin
                        // three-byte sequence broken after its first trailer
                        add_byte(8'hE0 | 8'($urandom_range(0, 15)), random_eot());
                        add_byte(random_trailer(), random_eot());
                        add_byte(random_breaker(), random_eot());
                    end
                endcase
            end
        end
    endtask

    // hands every queued item to the block; valid stays high between
    // back-to-back items and each payload holds while stalled
    task automatic send_text();
        t_text_item item;
        int         gap;
        while (text_q.size() > 0) begin
            item = text_q.pop_front();
            gap  = tx_idle ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_valid  <= 1'b1;
            text_byte   <= item.text_byte;
            end_of_text <= item.end_of_text;
            do @(posedge clk); while (byte_stall !== 1'b0);
            bytes_sent++;
        end
    endtask

    initial begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed text: ascii extremes
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        // two-byte sequence, then an overlong two-byte form
        add_byte(8'hC2, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hC0, 1'b0);
        add_byte(8'h80, 1'b0);
        // three-byte sequence, then the largest code unit
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b0);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        // broken two-byte sequence
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b0);
        // broken three-byte sequence with a trailer already held
        add_byte(8'hE4, 1'b0);
        add_byte(8'hB8, 1'b0);
        add_byte(8'h42, 1'b0);
        // stray trailer and a four-byte-and-up lead, both raw
        add_byte(8'h80, 1'b0);
        add_byte(8'hF8, 1'b0);
        // end of text flushing a lone lead, then a lead and its trailer
        add_byte(8'hE1, 1'b1);
        add_byte(8'hE1, 1'b0);
        add_byte(8'h81, 1'b1);
        // end of text with nothing pending
        add_byte(8'h41, 1'b1);
        // breaking byte is itself a lead that end of text flushes: three units
        add_byte(8'hE1, 1'b0);
        add_byte(8'h88, 1'b0);
        add_byte(8'hC5, 1'b1);
        send_text();

        // both sides idle at random
        add_random_text(130);
        send_text();

        // receiver holds off for a long stretch while bytes keep coming
        tx_idle      = 1'b0;
        hold_request = 120;
        add_random_text(40);
        send_text();

        // sender at full rate, receiver stalling at random
        add_random_text(100);
        send_text();

        // sender idling, receiver always ready
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        add_random_text(100);
        send_text();

        // no idling on either side
        tx_idle = 1'b0;
        add_random_text(50);
        send_text();
        byte_valid <= 1'b0;

        // drain the awaited units, then give stray units a chance to show
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d utf-8 bytes through directed, random and back-pressure phases",
                 bytes_sent);
        $display("checked %0d code units, %0d of them decoded from multi-byte sequences",
                 units_checked, units_decoded);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/u8d_pkg.sv
design/u8d_decode.sv
design/utf8_to_utf16_stream_decoder.sv
test/u8d_unit_checker.sv
test/tb_utf8_to_utf16_stream_decoder.sv
